// ===== src/windowed_average_trip_detector_assert.svh =====
// assertion macros for the windowed average trip detector
// used by the top level only; expects signals named clock and reset in scope
`ifndef WINDOWED_AVERAGE_TRIP_DETECTOR_ASSERT_SVH
`define WINDOWED_AVERAGE_TRIP_DETECTOR_ASSERT_SVH

// condition holds at every edge outside reset
`define TWA_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("twa invariant violated");

// condition on one edge implies a result at the next edge
`define TWA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("twa sequence violated");

// condition implies a result at the same edge
`define TWA_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("twa implication violated");

`endif

// ===== src/twa_pkg.sv =====
// types and constants shared by the windowed average trip detector
// no dependencies
`timescale 1ns / 1ps

package twa_pkg;

   localparam int SAMPLE_W = 12;
   localparam int SUM_W    = 16;
   localparam int CMP_W    = SAMPLE_W + 2;
   localparam int STATUS_W = 2;

   localparam logic [SAMPLE_W-1:0] MARGIN_RESET = 12'd100;

   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      PH_CALIBRATING = 2'd0,
      PH_MONITORING  = 2'd1,
      PH_TRIPPED     = 2'd2,
      PH_FAILED      = 2'd3
   } phase_type;

   typedef struct packed {
      logic                trip_now;
      phase_type           status;
      logic [SAMPLE_W-1:0] calibration;
      logic [SAMPLE_W-1:0] window_average;
   } result_type;

endpackage

// ===== src/twa_cell.sv =====
// one stage of the sample window shift line
// depends on twa_pkg
`timescale 1ns / 1ps

module twa_cell (
   input  logic                         clock,
   input  logic                         shift_en,
   input  logic [twa_pkg::SAMPLE_W-1:0] sample_in,
   output logic [twa_pkg::SAMPLE_W-1:0] sample_out
);
   import twa_pkg::*;

   logic [SAMPLE_W-1:0] sample_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;

endmodule

// ===== src/twa_mean.sv =====
// truncated mean of the window sum, divide by window size as reciprocal multiply
// depends on twa_pkg
`timescale 1ns / 1ps

module twa_mean #(
   parameter int WINDOW = 10
) (
   input  logic [twa_pkg::SUM_W-1:0]    sum,
   output logic [twa_pkg::SAMPLE_W-1:0] mean
);
   import twa_pkg::*;

   // shift of sum width plus five keeps floor exact for divisors up to 16
   localparam int RECIP_SHIFT = SUM_W + 5;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW);
   localparam int PROD_W = SUM_W + RECIP_W;

   logic [PROD_W-1:0] product;

   assign product = PROD_W'(sum) * PROD_W'(RECIP);
   assign mean    = product[RECIP_SHIFT +: SAMPLE_W];

endmodule

// ===== src/windowed_average_trip_detector.sv =====
// channel   | dir | handshake              | content
// req       | in  | req_tvalid/req_tready  | tdata: sample; tuser: kind
// rsp       | out | rsp_tvalid/rsp_tready  | tdata: average, calibration, status, trip
// csr       | in  | csr_valid/csr_ready    | trip margin
//
// one word per cycle while rsp is not stalled; each result appears in the cycle after its word is taken.
// the window sum update, reciprocal multiply and band compare are combinational.
// the output register is refilled in the cycle it is drained, so a stalled
// rsp side only stops req while a result is waiting and rsp_tready is low.
// synchronous reset: calibrating, no result pending, margin back to 100.
// depends on twa_pkg, twa_cell, twa_mean and the assertion header
`timescale 1ns / 1ps

module windowed_average_trip_detector #(
   parameter int WINDOW = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [11:0] sample, rest zero
   input  logic        req_tuser,  // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [11:0] window_average, [23:12] calibration,
                                   // [25:24] status, [26] trip_now, rest zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data
);
   import twa_pkg::*;

`include "windowed_average_trip_detector_assert.svh"

   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

   logic                req_accept;
   logic                kind;
   logic [SAMPLE_W-1:0] sample;

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   phase_type           phase_ff, phase_in;
   logic [SAMPLE_W-1:0] cal_ff, cal_in;
   logic [SAMPLE_W-1:0] margin_ff;
   logic                rsp_valid_ff;
   result_type          rsp_ff, result;

   logic                shift_en;
   logic [SAMPLE_W-1:0] cell_q [WINDOW];
   logic [SUM_W-1:0]    mean_sum;
   logic [SAMPLE_W-1:0] mean;
   logic [SUM_W-1:0]    sum_fill, sum_slide;
   logic signed [CMP_W-1:0] band_hi, band_lo, avg_s;

   assign kind       = req_tuser;
   assign sample     = req_tdata[SAMPLE_W-1:0];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // window shift line, oldest sample in cell 0, new sample enters the last cell
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      logic [SAMPLE_W-1:0] cell_in;
      if (i == WINDOW - 1) begin : g_tail
         assign cell_in = sample;
      end else begin : g_body
         assign cell_in = cell_q[i+1];
      end
      twa_cell u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .sample_in  (cell_in),
         .sample_out (cell_q[i])
      );
   end

   twa_mean #(.WINDOW(WINDOW)) u_mean (
      .sum  (mean_sum),
      .mean (mean)
   );

   assign sum_fill  = sum_ff + SUM_W'(sample);
   assign sum_slide = sum_ff - SUM_W'(cell_q[0]) + SUM_W'(sample);

   assign avg_s   = $signed({2'b00, mean});
   assign band_hi = $signed({2'b00, cal_ff}) + $signed({2'b00, margin_ff});
   assign band_lo = $signed({2'b00, cal_ff}) - $signed({2'b00, margin_ff});

   always_comb begin
      sum_in   = sum_ff;
      fill_in  = fill_ff;
      phase_in = phase_ff;
      cal_in   = cal_ff;
      shift_en = 1'b0;
      mean_sum = sum_ff;
      result   = '0;
      if (kind == KIND_RESTART) begin
         sum_in   = '0;
         fill_in  = '0;
         phase_in = PH_CALIBRATING;
         cal_in   = '0;
      end else begin
         case (phase_ff)
            PH_CALIBRATING: begin
               mean_sum = sum_fill;
               if (fill_ff < FILL_FULL) begin
                  shift_en = req_accept;
                  sum_in   = sum_fill;
                  fill_in  = fill_ff + 1'b1;
               end
               if (fill_in >= FILL_FULL) begin
                  result.window_average = mean;
                  if (mean == '0) begin
                     phase_in = PH_FAILED;
                     cal_in   = '0;
                  end else begin
                     phase_in = PH_MONITORING;
                     cal_in   = mean;
                  end
               end
            end
            PH_MONITORING: begin
               shift_en              = req_accept;
               sum_in                = sum_slide;
               mean_sum              = sum_slide;
               result.window_average = mean;
               if (band_hi < avg_s || band_lo > avg_s) begin
                  phase_in        = PH_TRIPPED;
                  result.trip_now = 1'b1;
               end
            end
            default: begin
               // tripped or failed: state held, mean of held window repeated
               result.window_average = mean;
            end
         endcase
      end
      result.calibration = cal_in;
      result.status      = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         fill_ff  <= '0;
         phase_ff <= PH_CALIBRATING;
         cal_ff   <= '0;
      end else if (req_accept) begin
         sum_ff   <= sum_in;
         fill_ff  <= fill_in;
         phase_ff <= phase_in;
         cal_ff   <= cal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else if (csr_valid && csr_ready) begin
         margin_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff};

   `TWA_ASSERT_ALWAYS(a_fill_bounded, fill_ff <= FILL_FULL)
   `TWA_ASSERT_IMPLY(a_monitor_full_window, phase_ff == PH_MONITORING, fill_ff == FILL_FULL)
   `TWA_ASSERT_NEXT(a_restart_clears, req_accept && kind == KIND_RESTART, fill_ff == '0 && sum_ff == '0 && phase_ff == PH_CALIBRATING)
   `TWA_ASSERT_IMPLY(a_trip_has_status, rsp_valid_ff && rsp_ff.trip_now, rsp_ff.status == PH_TRIPPED && phase_ff == PH_TRIPPED)

endmodule
